// File: design/gchg_pkg.sv
// gchg_pkg: shared types, codes and denomination tables for the change dispenser
// holds the fixed cent values and their scaled reciprocals used by the quotient step
// no dependencies
package gchg_pkg;

	localparam int DEF_NUM_DENOMS  = 13;
	localparam int DEF_COUNT_WIDTH = 16;

	localparam int MUL_W = 32;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_SALE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_INSUF = 2'd1,
		ST_NOCHG = 2'd2,
		ST_FAIL  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV_RECIP,
		S_DIV_QV,
		S_DIV_CORR,
		S_DIV_TV,
		S_DIV_SUB,
		S_CHECK,
		S_BAL_MUL,
		S_BAL_ACC,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic [MUL_W-1:0] a;
		logic [MUL_W-1:0] b;
	} mul_req_t;

	// cent value of each denomination, zero past the smallest coin
	function automatic logic [14:0] denom_value(input logic [3:0] i);
		logic [14:0] v;
		case (i)
			4'd0:    v = 15'd20000;
			4'd1:    v = 15'd10000;
			4'd2:    v = 15'd5000;
			4'd3:    v = 15'd2000;
			4'd4:    v = 15'd1000;
			4'd5:    v = 15'd500;
			4'd6:    v = 15'd200;
			4'd7:    v = 15'd100;
			4'd8:    v = 15'd50;
			4'd9:    v = 15'd25;
			4'd10:   v = 15'd10;
			4'd11:   v = 15'd5;
			4'd12:   v = 15'd1;
			default: v = 15'd0;
		endcase
		return v;
	endfunction

	// floor((2^32 - 1) / value): estimate is exact or one low for a 30-bit dividend
	function automatic logic [31:0] denom_recip(input logic [3:0] i);
		logic [31:0] m;
		case (i)
			4'd0:    m = 32'd214748;
			4'd1:    m = 32'd429496;
			4'd2:    m = 32'd858993;
			4'd3:    m = 32'd2147483;
			4'd4:    m = 32'd4294967;
			4'd5:    m = 32'd8589934;
			4'd6:    m = 32'd21474836;
			4'd7:    m = 32'd42949672;
			4'd8:    m = 32'd85899345;
			4'd9:    m = 32'd171798691;
			4'd10:   m = 32'd429496729;
			4'd11:   m = 32'd858993459;
			4'd12:   m = 32'd4294967295;
			default: m = 32'd0;
		endcase
		return m;
	endfunction

endpackage

// File: design/greedy_change_dispenser_unit.sv
// greedy_change_dispenser_unit: cash drawer stock with greedy change breakdown
// sequencer around one shared multiplier (gchg_mul), stock and breakdown registers
// depends on gchg_pkg, gchg_mul
//
// input channel in_valid/in_ready carries one command beat: cmd, denom_index,
// stock_value, price, paid, trial_only. in_ready is high only while the block idles.
// output channel out_valid/out_ready carries result beats: status, out_denom,
// used_count, change_amount, balance, last.
// load, insufficient payment and no change: one result beat, offered after a
// balance pass over every denomination.
// sale: each denomination passes through the multiplier states (reciprocal
// quotient, correction, deduction), then a check state and the balance pass;
// failure gives one beat, success NUM_DENOMS beats, one a cycle while the
// receiver is ready.
// the balance is always summed over the stock with the same multiplier.
// a stalled receiver holds the output register; the block waits in its
// result phase and takes a new input once the final beat is registered.
// reset clears every stock count to zero and empties the output register.
module greedy_change_dispenser_unit #(
	parameter int NUM_DENOMS  = gchg_pkg::DEF_NUM_DENOMS,
	parameter int COUNT_WIDTH = gchg_pkg::DEF_COUNT_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [3:0]  denom_index,
	input  logic [15:0] stock_value,
	input  logic [29:0] price,
	input  logic [29:0] paid,
	input  logic        trial_only,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [3:0]  out_denom,
	output logic [15:0] used_count,
	output logic [29:0] change_amount,
	output logic [31:0] balance,
	output logic        last
);
	import gchg_pkg::*;

	localparam int IDX_W = (NUM_DENOMS > 1) ? $clog2(NUM_DENOMS) : 1;

	state_t state_q, state_d;

	logic [COUNT_WIDTH-1:0] stock_q [NUM_DENOMS];
	logic [15:0]            scratch_q [NUM_DENOMS];

	logic [IDX_W-1:0] cnt_q;
	logic [29:0]      change_q;
	logic [29:0]      rest_q;
	logic [29:0]      qest_q;
	logic [31:0]      take_q;
	logic [31:0]      acc_q;
	status_t          op_status_q;
	logic             multi_q;
	logic             trial_q;

	logic        out_valid_q;
	logic [1:0]  status_q;
	logic [3:0]  out_denom_q;
	logic [15:0] used_count_q;
	logic [29:0] change_amount_q;
	logic [31:0] balance_q;
	logic        last_q;

	mul_req_t           mul_req;
	logic [2*MUL_W-1:0] prod;

	logic                   in_fire;
	logic                   out_free;
	logic                   out_load;
	logic                   cnt_last;
	logic [14:0]            cur_value;
	logic [31:0]            cur_recip;
	logic [COUNT_WIDTH-1:0] stock_rd;
	logic [29:0]            sale_change;
	logic [29:0]            rem_c;
	logic [29:0]            quot_c;
	logic [31:0]            take_c;

	gchg_mul u_mul (
		.clk  (clk),
		.req  (mul_req),
		.prod (prod)
	);

	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign cnt_last  = (cnt_q == IDX_W'(NUM_DENOMS - 1));
	assign cur_value = denom_value(4'(cnt_q));
	assign cur_recip = denom_recip(4'(cnt_q));
	assign stock_rd  = stock_q[cnt_q];
	assign sale_change = paid - price;

	// quotient correction and stock limit
	always_comb begin
		rem_c  = rest_q - prod[29:0];
		quot_c = qest_q + 30'(rem_c >= {15'd0, cur_value});
		if (cur_value == 15'd0) begin
			quot_c = 30'd0;
		end
		if (32'(quot_c) > 32'(stock_rd)) begin
			take_c = 32'(stock_rd);
		end else begin
			take_c = 32'(quot_c);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_load  = 1'b0;
		mul_req.a = '0;
		mul_req.b = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (cmd == CMD_SALE && paid > price) begin
						state_d = S_DIV_RECIP;
					end else begin
						state_d = S_BAL_MUL;
					end
				end
			end
			S_DIV_RECIP: begin
				mul_req.a = 32'(rest_q);
				mul_req.b = cur_recip;
				state_d   = S_DIV_QV;
			end
			S_DIV_QV: begin
				mul_req.a = 32'(prod[61:32]);
				mul_req.b = 32'(cur_value);
				state_d   = S_DIV_CORR;
			end
			S_DIV_CORR: begin
				state_d = S_DIV_TV;
			end
			S_DIV_TV: begin
				mul_req.a = take_q;
				mul_req.b = 32'(cur_value);
				state_d   = S_DIV_SUB;
			end
			S_DIV_SUB: begin
				state_d = cnt_last ? S_CHECK : S_DIV_RECIP;
			end
			S_CHECK: begin
				state_d = S_BAL_MUL;
			end
			S_BAL_MUL: begin
				mul_req.a = 32'(stock_rd);
				mul_req.b = 32'(cur_value);
				state_d   = S_BAL_ACC;
			end
			S_BAL_ACC: begin
				state_d = cnt_last ? S_EMIT : S_BAL_MUL;
			end
			S_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					if (!multi_q || cnt_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// sequencer datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cnt_q   <= '0;
				acc_q   <= '0;
				trial_q <= trial_only;
				multi_q <= 1'b0;
				rest_q  <= sale_change;
				if (cmd == CMD_LOAD) begin
					op_status_q <= ST_OK;
					change_q    <= '0;
				end else if (paid < price) begin
					op_status_q <= ST_INSUF;
					change_q    <= '0;
				end else if (paid == price) begin
					op_status_q <= ST_NOCHG;
					change_q    <= '0;
				end else begin
					op_status_q <= ST_OK;
					change_q    <= sale_change;
				end
			end
			S_DIV_QV: begin
				qest_q <= prod[61:32];
			end
			S_DIV_CORR: begin
				take_q <= take_c;
			end
			S_DIV_SUB: begin
				rest_q <= rest_q - prod[29:0];
				scratch_q[cnt_q] <= take_q[15:0];
				cnt_q <= cnt_last ? '0 : cnt_q + IDX_W'(1);
			end
			S_CHECK: begin
				if (rest_q != 30'd0) begin
					op_status_q <= ST_FAIL;
				end else begin
					multi_q <= 1'b1;
				end
			end
			S_BAL_ACC: begin
				acc_q <= acc_q + prod[31:0];
				cnt_q <= cnt_last ? '0 : cnt_q + IDX_W'(1);
			end
			S_EMIT: begin
				if (out_free) begin
					cnt_q <= cnt_q + IDX_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// stock counts: load write, or deduction of a successful non-trial sale
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_DENOMS; i++) begin
				stock_q[i] <= '0;
			end
		end else if (in_fire && cmd == CMD_LOAD) begin
			if ({1'b0, denom_index} < 5'(NUM_DENOMS)) begin
				stock_q[denom_index[IDX_W-1:0]] <= COUNT_WIDTH'(stock_value);
			end
		end else if (state_q == S_CHECK && rest_q == 30'd0 && !trial_q) begin
			for (int i = 0; i < NUM_DENOMS; i++) begin
				stock_q[i] <= stock_q[i] - COUNT_WIDTH'(scratch_q[i]);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q        <= op_status_q;
			out_denom_q     <= multi_q ? 4'(cnt_q) : 4'd0;
			used_count_q    <= multi_q ? scratch_q[cnt_q] : 16'd0;
			change_amount_q <= change_q;
			balance_q       <= acc_q;
			last_q          <= !multi_q || cnt_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign out_denom     = out_denom_q;
	assign used_count    = used_count_q;
	assign change_amount = change_amount_q;
	assign balance       = balance_q;
	assign last          = last_q;

endmodule

// File: design/gchg_mul.sv
// gchg_mul: shared 32 by 32 multiplier with a registered 64-bit product
// one request a cycle, product valid the cycle after
// depends on gchg_pkg
module gchg_mul (
	input  logic                      clk,
	input  gchg_pkg::mul_req_t        req,
	output logic [2*gchg_pkg::MUL_W-1:0] prod
);
	import gchg_pkg::*;

	logic [2*MUL_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= req.a * req.b;
	end

	assign prod = prod_q;

endmodule
